FILE: rtl/glyph_coverage_compositor_unit_assert.svh
// Assertion macros shared by the compositor RTL.
// Each macro is clocked on i_clk and disabled while i_rst_n is low.
`ifndef GLYPH_COVERAGE_COMPOSITOR_UNIT_ASSERT_SVH
`define GLYPH_COVERAGE_COMPOSITOR_UNIT_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define GCOMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define GCOMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/gcomp_pkg.sv
// Shared types, register codes and arithmetic helpers for the glyph compositor.
// Used by glyph_coverage_compositor_unit and its bench; depends on nothing.
package gcomp_pkg;

    localparam int CHAN_W    = 8;
    localparam int PROD_W    = 2 * CHAN_W;
    localparam int CFG_IDX_W = 3;
    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEXT_RED   = 3'd0,
        REG_TEXT_GREEN = 3'd1,
        REG_TEXT_BLUE  = 3'd2,
        REG_TEXT_ALPHA = 3'd3,
        REG_BLEND_MODE = 3'd4
    } t_cfg_reg;

    typedef enum logic {
        MODE_KEEP_STRONGEST = 1'b0,
        MODE_SOURCE_OVER    = 1'b1
    } t_blend_mode;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_pixel;

    // After the coverage-times-opacity product.
    typedef struct packed {
        logic [CHAN_W-1:0] cov;
        t_pixel            dst;
        logic [PROD_W-1:0] alpha_prod;
    } t_s1;

    // Source alpha and its complement are known here.
    typedef struct packed {
        logic              cov_nz;
        logic [CHAN_W-1:0] cov;
        logic [CHAN_W-1:0] src_a;
        logic [CHAN_W-1:0] inv_a;
        t_pixel            dst;
    } t_s2;

    // All channel products, still undivided.
    typedef struct packed {
        logic              cov_nz;
        logic [CHAN_W-1:0] src_a;
        t_pixel            dst;
        logic [PROD_W-1:0] src_r;
        logic [PROD_W-1:0] src_g;
        logic [PROD_W-1:0] src_b;
        logic [PROD_W-1:0] dst_r;
        logic [PROD_W-1:0] dst_g;
        logic [PROD_W-1:0] dst_b;
        logic [PROD_W-1:0] dst_a;
    } t_s3;

    typedef struct packed {
        t_pixel pix;
        logic   written;
    } t_res;

    // Truncating division by 255, exact for every product of two 8-bit values.
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] t;
        t = {1'b0, x} + (PROD_W+1)'(x[PROD_W-1:CHAN_W]) + (PROD_W+1)'(1);
        return t[PROD_W-1:CHAN_W];
    endfunction

endpackage

FILE: rtl/glyph_coverage_compositor_unit.sv
// Glyph coverage compositor: scales coverage by text opacity and blends the
// text colour into a premultiplied RGBA pixel. Uses gcomp_pkg and gcomp_stage.
//
// Usage:
// - Input channel (i_in_valid / o_in_ready) takes one transaction per pixel:
//   coverage plus the destination pixel. Output channel (o_out_valid /
//   i_out_ready) returns one transaction per pixel, in order, with the new
//   pixel and a flag that tells whether it was modified.
// - Configuration channel (i_cfg_valid / o_cfg_ready) writes the text colour,
//   opacity and blend mode by register index; it is always ready. Write it
//   only while no pixel is in flight. Indexes beyond the list are ignored.
// - An accepted pixel passes through the four register stages in order:
//   opacity product, divide by 255, channel products, divide, sum and select.
//   The result is held in the last stage until it is taken. Throughput is one
//   pixel per cycle while the receiver is ready.
// - Reset clears all stage valid bits and loads white, fully opaque text in
//   keep-strongest mode.
// - When the receiver stalls, the stages fill up one by one; the input side
//   keeps accepting until every stage holds a pixel. Nothing is lost or
//   repeated.
module glyph_coverage_compositor_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gcomp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gcomp_pkg::CHAN_W-1:0]    i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [gcomp_pkg::CHAN_W-1:0]    i_coverage,
    input  logic [gcomp_pkg::CHAN_W-1:0]    i_dst_red,
    input  logic [gcomp_pkg::CHAN_W-1:0]    i_dst_green,
    input  logic [gcomp_pkg::CHAN_W-1:0]    i_dst_blue,
    input  logic [gcomp_pkg::CHAN_W-1:0]    i_dst_alpha,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [gcomp_pkg::CHAN_W-1:0]    o_out_red,
    output logic [gcomp_pkg::CHAN_W-1:0]    o_out_green,
    output logic [gcomp_pkg::CHAN_W-1:0]    o_out_blue,
    output logic [gcomp_pkg::CHAN_W-1:0]    o_out_alpha,
    output logic                            o_pixel_written
);
    import gcomp_pkg::*;
    `include "glyph_coverage_compositor_unit_assert.svh"

    logic [CHAN_W-1:0] r_text_red;
    logic [CHAN_W-1:0] r_text_green;
    logic [CHAN_W-1:0] r_text_blue;
    logic [CHAN_W-1:0] r_text_alpha;
    t_blend_mode       r_blend_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_red   <= FULL_SCALE;
            r_text_green <= FULL_SCALE;
            r_text_blue  <= FULL_SCALE;
            r_text_alpha <= FULL_SCALE;
            r_blend_mode <= MODE_KEEP_STRONGEST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TEXT_RED:   r_text_red   <= i_cfg_data;
                REG_TEXT_GREEN: r_text_green <= i_cfg_data;
                REG_TEXT_BLUE:  r_text_blue  <= i_cfg_data;
                REG_TEXT_ALPHA: r_text_alpha <= i_cfg_data;
                REG_BLEND_MODE: r_blend_mode <= t_blend_mode'(i_cfg_data[0]);
                default: ;
            endcase
        end
    end

    // Stage handshake wires.
    logic s1_valid, s1_ready, s2_valid, s2_ready, s3_valid, s3_ready;
    t_s1  n_s1, s1_q;
    t_s2  n_s2, s2_q;
    t_s3  n_s3, s3_q;
    t_res n_res, res_q;

    // Stage 1: coverage times opacity.
    always_comb begin
        n_s1.cov        = i_coverage;
        n_s1.dst.red    = i_dst_red;
        n_s1.dst.green  = i_dst_green;
        n_s1.dst.blue   = i_dst_blue;
        n_s1.dst.alpha  = i_dst_alpha;
        n_s1.alpha_prod = i_coverage * r_text_alpha;
    end

    gcomp_stage #(.W($bits(t_s1))) u_s1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_ready(o_in_ready), .i_data(n_s1),
        .o_valid(s1_valid), .i_ready(s1_ready), .o_data(s1_q)
    );

    // Stage 2: source alpha and its complement.
    always_comb begin
        n_s2.cov    = s1_q.cov;
        n_s2.cov_nz = (s1_q.cov != '0);
        n_s2.src_a  = div255(s1_q.alpha_prod);
        n_s2.inv_a  = FULL_SCALE - n_s2.src_a;
        n_s2.dst    = s1_q.dst;
    end

    gcomp_stage #(.W($bits(t_s2))) u_s2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s1_valid), .o_ready(s1_ready), .i_data(n_s2),
        .o_valid(s2_valid), .i_ready(s2_ready), .o_data(s2_q)
    );

    // Stage 3: one product per channel for the source and destination terms.
    always_comb begin
        n_s3.cov_nz = s2_q.cov_nz;
        n_s3.src_a  = s2_q.src_a;
        n_s3.dst    = s2_q.dst;
        n_s3.src_r  = r_text_red * s2_q.src_a;
        n_s3.src_g  = r_text_green * s2_q.src_a;
        n_s3.src_b  = r_text_blue * s2_q.src_a;
        n_s3.dst_r  = s2_q.dst.red * s2_q.inv_a;
        n_s3.dst_g  = s2_q.dst.green * s2_q.inv_a;
        n_s3.dst_b  = s2_q.dst.blue * s2_q.inv_a;
        n_s3.dst_a  = s2_q.dst.alpha * s2_q.inv_a;
    end

    gcomp_stage #(.W($bits(t_s3))) u_s3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s2_valid), .o_ready(s2_ready), .i_data(n_s3),
        .o_valid(s3_valid), .i_ready(s3_ready), .o_data(s3_q)
    );

    // Stage 4: divide, sum and pick the result. Sums never pass 255, so the
    // low byte is the whole value.
    logic              active;
    logic [CHAN_W-1:0] src_r, src_g, src_b;
    logic [CHAN_W:0]   sum_r, sum_g, sum_b, sum_a;

    always_comb begin
        active = s3_q.cov_nz && (s3_q.src_a != '0);
        src_r  = div255(s3_q.src_r);
        src_g  = div255(s3_q.src_g);
        src_b  = div255(s3_q.src_b);
        sum_r  = {1'b0, src_r} + {1'b0, div255(s3_q.dst_r)};
        sum_g  = {1'b0, src_g} + {1'b0, div255(s3_q.dst_g)};
        sum_b  = {1'b0, src_b} + {1'b0, div255(s3_q.dst_b)};
        sum_a  = {1'b0, s3_q.src_a} + {1'b0, div255(s3_q.dst_a)};
        n_res.pix     = s3_q.dst;
        n_res.written = 1'b0;
        if (active) begin
            unique case (r_blend_mode)
                MODE_SOURCE_OVER: begin
                    n_res.pix.red   = sum_r[CHAN_W-1:0];
                    n_res.pix.green = sum_g[CHAN_W-1:0];
                    n_res.pix.blue  = sum_b[CHAN_W-1:0];
                    n_res.pix.alpha = sum_a[CHAN_W-1:0];
                    n_res.written   = 1'b1;
                end
                MODE_KEEP_STRONGEST: begin
                    if (s3_q.src_a > s3_q.dst.alpha) begin
                        n_res.pix.red   = src_r;
                        n_res.pix.green = src_g;
                        n_res.pix.blue  = src_b;
                        n_res.pix.alpha = s3_q.src_a;
                        n_res.written   = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    gcomp_stage #(.W($bits(t_res))) u_s4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s3_valid), .o_ready(s3_ready), .i_data(n_res),
        .o_valid(o_out_valid), .i_ready(i_out_ready), .o_data(res_q)
    );

    assign o_out_red       = res_q.pix.red;
    assign o_out_green     = res_q.pix.green;
    assign o_out_blue      = res_q.pix.blue;
    assign o_out_alpha     = res_q.pix.alpha;
    assign o_pixel_written = res_q.written;

    // The input may only be refused when every stage is occupied.
    `GCOMP_ASSERT_NOW(a_full_when_blocked, !o_in_ready,
        s1_valid && s2_valid && s3_valid && o_out_valid,
        "input refused while a pipeline stage is empty")

    // Source alpha can never exceed the coverage it came from.
    `GCOMP_ASSERT_NOW(a_src_alpha_bound, s2_valid, s2_q.src_a <= s2_q.cov,
        "source alpha larger than coverage")

    // A stalled stage 3 pixel must still be there next cycle.
    `GCOMP_ASSERT_NEXT(a_s3_hold, s3_valid && !s3_ready, s3_valid,
        "stalled pixel dropped from stage 3")

    // A keep-strongest write stores premultiplied colour, never above alpha.
    `GCOMP_ASSERT_NOW(a_keep_premult,
        o_out_valid && o_pixel_written && (r_blend_mode == MODE_KEEP_STRONGEST),
        (o_out_red <= o_out_alpha) && (o_out_green <= o_out_alpha)
            && (o_out_blue <= o_out_alpha),
        "keep-strongest result is not premultiplied")

endmodule

FILE: rtl/gcomp_stage.sv
// One pipeline register stage with a valid/ready handshake on each side.
// Generic in payload width; used by glyph_coverage_compositor_unit.
module gcomp_stage #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic         r_valid;
    logic [W-1:0] r_data;

    // The stage can load whenever it is empty or its content leaves this cycle.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

FILE: bench/gcomp_bench_pkg.sv
`timescale 1ns / 100ps
// Pixel scoreboard for the glyph coverage compositor bench.
// Depends on gcomp_pkg for the pixel, result, blend mode and register types.
package gcomp_bench_pkg;
    import gcomp_pkg::*;

    localparam int unsigned REPORT_LIMIT = 60;

    class composite_scoreboard;
        logic [CHAN_W-1:0] text_red;
        logic [CHAN_W-1:0] text_green;
        logic [CHAN_W-1:0] text_blue;
        logic [CHAN_W-1:0] text_alpha;
        t_blend_mode       mode;
        t_res              expected_pixels[$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       wrote_count[2];
        int unsigned       passed_count[2];

        function new();
            text_red        = FULL_SCALE;
            text_green      = FULL_SCALE;
            text_blue       = FULL_SCALE;
            text_alpha      = FULL_SCALE;
            mode            = MODE_KEEP_STRONGEST;
            errors          = 0;
            checked         = 0;
            wrote_count     = '{0, 0};
            passed_count    = '{0, 0};
        endfunction

        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CHAN_W-1:0] data);
            case (idx)
                REG_TEXT_RED:   text_red   = data;
                REG_TEXT_GREEN: text_green = data;
                REG_TEXT_BLUE:  text_blue  = data;
                REG_TEXT_ALPHA: text_alpha = data;
                REG_BLEND_MODE: mode       = t_blend_mode'(data[0]);
                default: ;
            endcase
        endfunction

        function int unsigned frac255(int unsigned x, int unsigned f);
            return (x * f) / FULL_SCALE;
        endfunction

        function t_res composite(logic [CHAN_W-1:0] cov, t_pixel dst);
            t_res        res;
            int unsigned src_a;
            int unsigned inv_a;
            res.pix     = dst;
            res.written = 1'b0;
            src_a = frac255(cov, text_alpha);
            if (cov != 0 && src_a != 0) begin
                if (mode == MODE_KEEP_STRONGEST) begin
                    // The text only replaces the pixel when it is strictly stronger.
                    if (src_a > dst.alpha) begin
                        res.pix.red   = CHAN_W'(frac255(text_red, src_a));
                        res.pix.green = CHAN_W'(frac255(text_green, src_a));
                        res.pix.blue  = CHAN_W'(frac255(text_blue, src_a));
                        res.pix.alpha = CHAN_W'(src_a);
                        res.written   = 1'b1;
                    end
                end else begin
                    inv_a = FULL_SCALE - src_a;
                    res.pix.red   = CHAN_W'(frac255(text_red, src_a)
                                            + frac255(dst.red, inv_a));
                    res.pix.green = CHAN_W'(frac255(text_green, src_a)
                                            + frac255(dst.green, inv_a));
                    res.pix.blue  = CHAN_W'(frac255(text_blue, src_a)
                                            + frac255(dst.blue, inv_a));
                    res.pix.alpha = CHAN_W'(src_a + frac255(dst.alpha, inv_a));
                    res.written   = 1'b1;
                end
            end
            return res;
        endfunction

        function void note_pixel(logic [CHAN_W-1:0] cov, t_pixel dst);
            t_res res;
            res = composite(cov, dst);
            expected_pixels.push_back(res);
            if (res.written)
                wrote_count[mode]++;
            else
                passed_count[mode]++;
        endfunction

        function void compare(string field, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_pixel(t_pixel got, logic got_written);
            t_res want;
            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: result transaction with no pixel outstanding", $time);
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            compare("out_red", want.pix.red, got.red);
            compare("out_green", want.pix.green, got.green);
            compare("out_blue", want.pix.blue, got.blue);
            compare("out_alpha", want.pix.alpha, got.alpha);
            compare("pixel_written", {7'd0, want.written}, {7'd0, got_written});
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction
    endclass

endpackage

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Top-level bench for glyph_coverage_compositor_unit: directed and random pixels
// under random input gaps and output stalls, checked by the scoreboard.
// Depends on gcomp_pkg and gcomp_bench_pkg.
module testbench;
    import gcomp_pkg::*;
    import gcomp_bench_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 3;
    localparam int RANDOM_PHASES    = 10;
    localparam int PHASE_ITEMS      = 125;
    localparam int HOLD_PHASE       = 4;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int TAIL_CYCLES      = 8;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int unsigned FIRST_UNMAPPED = int'(REG_BLEND_MODE) + 1;
    localparam int unsigned LAST_INDEX     = (1 << CFG_IDX_W) - 1;

    typedef enum {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_SPARSE} t_rx_pattern;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [CHAN_W-1:0]    i_cfg_data      = '0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_ready;
    logic [CHAN_W-1:0]    i_coverage      = '0;
    logic [CHAN_W-1:0]    i_dst_red       = '0;
    logic [CHAN_W-1:0]    i_dst_green     = '0;
    logic [CHAN_W-1:0]    i_dst_blue      = '0;
    logic [CHAN_W-1:0]    i_dst_alpha     = '0;
    logic                 o_out_valid;
    logic                 i_out_ready     = 1'b0;
    logic [CHAN_W-1:0]    o_out_red;
    logic [CHAN_W-1:0]    o_out_green;
    logic [CHAN_W-1:0]    o_out_blue;
    logic [CHAN_W-1:0]    o_out_alpha;
    logic                 o_pixel_written;

    composite_scoreboard scoreboard;
    bit                  long_hold_req     = 1'b0;
    int unsigned         hold_cycles_total = 0;
    int unsigned         n_cfg_writes      = 0;
    int unsigned         n_settings        = 0;
    int unsigned         idle_cycles       = 0;
    int                  burst_left        = 0;

    glyph_coverage_compositor_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_coverage      (i_coverage),
        .i_dst_red       (i_dst_red),
        .i_dst_green     (i_dst_green),
        .i_dst_blue      (i_dst_blue),
        .i_dst_alpha     (i_dst_alpha),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_red       (o_out_red),
        .o_out_green     (o_out_green),
        .o_out_blue      (o_out_blue),
        .o_out_alpha     (o_out_alpha),
        .o_pixel_written (o_pixel_written)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Valid stays high after an accepted transaction; the caller lowers it when
    // the burst ends.
    task automatic send_pixel(input logic [CHAN_W-1:0] cov, input t_pixel dst);
        i_in_valid  <= 1'b1;
        i_coverage  <= cov;
        i_dst_red   <= dst.red;
        i_dst_green <= dst.green;
        i_dst_blue  <= dst.blue;
        i_dst_alpha <= dst.alpha;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        scoreboard.note_pixel(cov, dst);
    endtask

    task automatic pause_input(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Every pixel yields a result, so an empty scoreboard means an empty pipeline.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        scoreboard.apply_write(idx, data);
        n_cfg_writes++;
    endtask

    // In sparse mode some registers keep their old value and a stray write to
    // an unmapped index may be thrown in.
    task automatic program_registers(input logic [CHAN_W-1:0] red, green, blue, alpha,
                                     input logic [CHAN_W-1:0] mode_data, input bit sparse);
        if (!sparse || $urandom_range(0, 3) != 0) write_reg(REG_TEXT_RED, red);
        if (!sparse || $urandom_range(0, 3) != 0) write_reg(REG_TEXT_GREEN, green);
        if (!sparse || $urandom_range(0, 3) != 0) write_reg(REG_TEXT_BLUE, blue);
        if (!sparse || $urandom_range(0, 3) != 0) write_reg(REG_TEXT_ALPHA, alpha);
        if (!sparse || $urandom_range(0, 3) != 0) write_reg(REG_BLEND_MODE, mode_data);
        if (sparse && $urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(FIRST_UNMAPPED, LAST_INDEX)),
                      CHAN_W'($urandom_range(0, 255)));
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [CHAN_W-1:0] random_level();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return FULL_SCALE;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_pixel(output logic [CHAN_W-1:0] cov, output t_pixel dst);
        int unsigned a;
        case ($urandom_range(0, 9))
            0:       cov = 8'd0;
            1:       cov = FULL_SCALE;
            2:       cov = CHAN_W'($urandom_range(1, 3));
            default: cov = CHAN_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 4))
            0, 1: begin
                // Well-formed premultiplied pixel: no channel above its alpha.
                a         = $urandom_range(0, 255);
                dst.alpha = CHAN_W'(a);
                dst.red   = CHAN_W'($urandom_range(0, a));
                dst.green = CHAN_W'($urandom_range(0, a));
                dst.blue  = CHAN_W'($urandom_range(0, a));
            end
            2, 3: dst = $urandom;
            default: begin
                dst.red   = $urandom_range(0, 1) ? FULL_SCALE : 8'd0;
                dst.green = $urandom_range(0, 1) ? FULL_SCALE : 8'd0;
                dst.blue  = $urandom_range(0, 1) ? FULL_SCALE : 8'd0;
                dst.alpha = $urandom_range(0, 1) ? FULL_SCALE : 8'd0;
            end
        endcase
    endtask

    // Result checking; outputs and ready are sampled as they stood at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            scoreboard.check_pixel({o_out_red, o_out_green, o_out_blue, o_out_alpha},
                                   o_pixel_written);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("glyph_coverage_compositor_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Output side: random stall patterns, plus one long hold-off on request.
    initial begin : receiver
        t_rx_pattern pattern;
        int          span;
        int          k;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                hold_cycles_total += LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end else begin
                pattern = t_rx_pattern'($urandom_range(0, 3));
                span    = $urandom_range(4, 64);
                for (k = 0; k < span; k++) begin
                    case (pattern)
                        RX_STEADY:   i_out_ready <= 1'b1;
                        RX_RANDOM:   i_out_ready <= 1'($urandom_range(0, 1));
                        RX_PERIODIC: i_out_ready <= (k % 4) != 3;
                        default:     i_out_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin : stimulus
        logic [CHAN_W-1:0] cov;
        logic [CHAN_W-1:0] mode_data;
        t_pixel            dst;
        int                ph;
        int                count;
        int unsigned       idx;

        scoreboard = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: opaque white text, keep-strongest.
        send_pixel(8'd0,   {8'd10, 8'd20, 8'd30, 8'd40});
        send_pixel(8'd255, {8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel(8'd255, {8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel(8'd128, {8'd1, 8'd2, 8'd3, 8'd128});
        send_pixel(8'd129, {8'd1, 8'd2, 8'd3, 8'd128});
        send_pixel(8'd1,   {8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel(8'd200, {8'd255, 8'd255, 8'd255, 8'd0});

        // Source-over; only bit 0 of the mode data counts.
        drain();
        program_registers(8'd0, 8'd255, 8'd90, 8'd255, 8'hFF, 1'b0);
        send_pixel(8'd255, {8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel(8'd255, {8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel(8'd0,   {8'd12, 8'd34, 8'd56, 8'd78});
        send_pixel(8'd1,   {8'd255, 8'd255, 8'd255, 8'd0});
        send_pixel(8'd128, {8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel(8'd17,  {8'd200, 8'd100, 8'd50, 8'd60});

        // Zero opacity: every pixel passes through.
        drain();
        program_registers(8'd0, 8'd255, 8'd90, 8'd0, 8'h01, 1'b0);
        send_pixel(8'd255, {8'd1, 8'd2, 8'd3, 8'd4});
        send_pixel(8'd128, {8'd9, 8'd8, 8'd7, 8'd6});

        // Unmapped indexes must leave the registers alone; opacity 1 truncates
        // most coverage to a zero source alpha.
        drain();
        for (idx = FIRST_UNMAPPED; idx <= LAST_INDEX; idx++)
            write_reg(CFG_IDX_W'(idx), 8'hFF);
        program_registers(8'd255, 8'd255, 8'd255, 8'd1, 8'h02, 1'b0);
        send_pixel(8'd254, {8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel(8'd255, {8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel(8'd255, {8'd1, 8'd1, 8'd1, 8'd1});

        // Source-over that reproduces the destination still counts as a write.
        drain();
        program_registers(8'd255, 8'd255, 8'd255, 8'd1, 8'h81, 1'b0);
        send_pixel(8'd255, {8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel(8'd254, {8'd255, 8'd255, 8'd255, 8'd255});

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            mode_data = CHAN_W'(($urandom_range(0, 127) << 1) | (ph % 2));
            if (ph == 0)
                program_registers(8'd255, 8'd255, 8'd255, 8'd255, mode_data, 1'b0);
            else if (ph == 1)
                program_registers(8'd0, 8'd0, 8'd0, 8'd255, mode_data, 1'b0);
            else
                program_registers(random_level(), random_level(), random_level(),
                                  random_level(), mode_data, 1'b1);
            // The hold phase sends back to back so the stalled pipeline backs up.
            if (ph == HOLD_PHASE)
                long_hold_req = 1'b1;
            count      = 0;
            burst_left = $urandom_range(1, 64);
            while (count < PHASE_ITEMS || long_hold_req) begin
                if (!long_hold_req && burst_left == 0) begin
                    pause_input($urandom_range(1, 12));
                    burst_left = $urandom_range(1, 64);
                end
                random_pixel(cov, dst);
                send_pixel(cov, dst);
                count++;
                if (burst_left > 0)
                    burst_left--;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Composited %0d pixels over %0d register settings: keep-strongest wrote %0d"
                 , scoreboard.checked, n_settings, scoreboard.wrote_count[MODE_KEEP_STRONGEST]);
        $display({"and passed %0d, source-over wrote %0d and passed %0d; ",
                  "%0d register writes, %0d cycles of output hold-off."},
                 scoreboard.passed_count[MODE_KEEP_STRONGEST],
                 scoreboard.wrote_count[MODE_SOURCE_OVER],
                 scoreboard.passed_count[MODE_SOURCE_OVER], n_cfg_writes, hold_cycles_total);
        if (scoreboard.errors == 0 && scoreboard.pending() == 0)
            $display("glyph_coverage_compositor_unit: match");
        else
            $display("glyph_coverage_compositor_unit: mismatch");
        $finish;
    end

endmodule
